>>> sv/sesp_pkg.sv
`timescale 1ns / 1ps
package sesp_pkg;

	localparam int RADIUS_W = 7;
	localparam int TRIG_W   = 16;
	localparam int SCALE_W  = 16;
	localparam int COUNT_W  = 9;
	localparam int COORD_W  = 8;
	localparam int SHADE_W  = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int RADIUS_MAX_DEF = 127;
	localparam int SHADES_MAX_DEF = 256;

	localparam int DELTA_W = COORD_W + 1;
	localparam int PROD_W  = TRIG_W + DELTA_W;
	localparam int ROT_W   = PROD_W + 1;
	localparam int MAG_W   = 24;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int HALF_W  = SQ_W / 2;
	localparam int PP_W    = SCALE_W + HALF_W;
	localparam int LO_W    = SQ_W + 9;
	localparam int SUM_W   = 64;
	localparam int RSQ_SHIFT = 36;
	localparam int RSQ_W   = SUM_W - RSQ_SHIFT;
	localparam int R0SQ_W  = 2 * RADIUS_W;
	localparam int NN_W    = 2 * COUNT_W;
	localparam int T_W     = R0SQ_W + NN_W;
	localparam int ROOT_W  = COUNT_W;
	localparam int Q_W     = ROOT_W + R0SQ_W;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COS        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIN        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SEL  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SHADE_EN   = 3'd6;

endpackage

>>> sv/shaded_ellipse_sprite_pixel.sv
`timescale 1ns / 1ps
// channel  signals                              dir  notes
// pix      pix_valid pix_stall col row          in   one pixel item per handshake
// res      res_valid res_stall inside_res       out  one result item per pixel
//          shade_index
// cfg      cfg_valid cfg_ready cfg_index        in   register write, ready always high
//          cfg_data
//
// the pipeline has 7 arithmetic stages, 9 square root stages and the output
// register; one item per cycle enters when the first stage is free
// the square root is a bit-serial search, one result bit per pipeline stage
// each stage holds its item unless the next stage is empty or moving on, so
// bubbles close up under a stalled output and nothing is lost or repeated
// asynchronous active-low reset empties the pipeline and loads register defaults
module shaded_ellipse_sprite_pixel #(
	parameter int RADIUS_MAX = sesp_pkg::RADIUS_MAX_DEF,
	parameter int SHADES_MAX = sesp_pkg::SHADES_MAX_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  pix_valid,
	output logic                                  pix_stall,
	input  logic [sesp_pkg::COORD_W-1:0]          col,
	input  logic [sesp_pkg::COORD_W-1:0]          row,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic                                  inside_res,
	output logic [sesp_pkg::SHADE_W-1:0]          shade_index,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sesp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sesp_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int NR      = sesp_pkg::ROOT_W;
	localparam int ST_ROOT = 7;
	localparam int ST_OUT  = ST_ROOT + NR;
	localparam int NST     = ST_OUT + 1;

	// configuration registers
	logic [sesp_pkg::RADIUS_W-1:0]        radius_q;
	logic signed [sesp_pkg::TRIG_W-1:0]   cos_q;
	logic signed [sesp_pkg::TRIG_W-1:0]   sin_q;
	logic [sesp_pkg::SCALE_W-1:0]         scale_q;
	logic                                 scale_sel_q;
	logic [sesp_pkg::COUNT_W-1:0]         count_q;
	logic                                 shade_en_q;

	logic [sesp_pkg::RADIUS_W-1:0]        rc;
	logic [sesp_pkg::COUNT_W-1:0]         nc;
	logic [sesp_pkg::R0SQ_W-1:0]          r0sq_q;
	logic [sesp_pkg::NN_W-1:0]            nn_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= '0;
			cos_q       <= 16'sd16384;
			sin_q       <= '0;
			scale_q     <= 16'd256;
			scale_sel_q <= 1'b0;
			count_q     <= 9'd1;
			shade_en_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sesp_pkg::CFG_RADIUS:    radius_q    <= cfg_data[sesp_pkg::RADIUS_W-1:0];
				sesp_pkg::CFG_COS:       cos_q       <= $signed(cfg_data);
				sesp_pkg::CFG_SIN:       sin_q       <= $signed(cfg_data);
				sesp_pkg::CFG_SCALE:     scale_q     <= cfg_data;
				sesp_pkg::CFG_SCALE_SEL: scale_sel_q <= cfg_data[0];
				sesp_pkg::CFG_COUNT:     count_q     <= cfg_data[sesp_pkg::COUNT_W-1:0];
				sesp_pkg::CFG_SHADE_EN:  shade_en_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamped radius and shade count, squared into registers
	assign rc = (32'(radius_q) > RADIUS_MAX) ? sesp_pkg::RADIUS_W'(RADIUS_MAX) : radius_q;
	assign nc = (32'(count_q) > SHADES_MAX) ? sesp_pkg::COUNT_W'(SHADES_MAX) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0sq_q <= '0;
			nn_q   <= sesp_pkg::NN_W'(1);
		end else begin
			r0sq_q <= rc * rc;
			nn_q   <= nc * nc;
		end
	end

	// stage handshake
	logic [NST-1:0] vld_s;
	logic [NST-1:0] go;

	always_comb begin
		go[NST-1] = !vld_s[NST-1] || !res_stall;
		for (int i = NST - 2; i >= 0; i--) begin
			go[i] = !vld_s[i] || go[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (go[0]) begin
				vld_s[0] <= pix_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (go[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	assign pix_stall = !go[0];
	assign res_valid = vld_s[NST-1];

	// stage 1: offset from centre and rotation products
	logic signed [sesp_pkg::DELTA_W-1:0] dx, dy;
	logic signed [sesp_pkg::PROD_W-1:0]  cdx_s1, sdy_s1, sdx_s1, cdy_s1;

	assign dx = $signed({1'b0, col}) - $signed({2'b00, rc});
	assign dy = $signed({1'b0, row}) - $signed({2'b00, rc});

	always_ff @(posedge clk) begin
		if (go[0]) begin
			cdx_s1 <= cos_q * dx;
			sdy_s1 <= sin_q * dy;
			sdx_s1 <= sin_q * dx;
			cdy_s1 <= cos_q * dy;
		end
	end

	// stage 2: rotated axes, magnitudes
	logic signed [sesp_pkg::ROT_W-1:0] ra, rb, ra_abs, rb_abs;
	logic [sesp_pkg::MAG_W-1:0]        ma_s2, mb_s2;

	assign ra = sesp_pkg::ROT_W'(cdx_s1) - sesp_pkg::ROT_W'(sdy_s1);
	assign rb = sesp_pkg::ROT_W'(sdx_s1) + sesp_pkg::ROT_W'(cdy_s1);
	assign ra_abs = ra[sesp_pkg::ROT_W-1] ? -ra : ra;
	assign rb_abs = rb[sesp_pkg::ROT_W-1] ? -rb : rb;

	always_ff @(posedge clk) begin
		if (go[1]) begin
			ma_s2 <= ra_abs[sesp_pkg::MAG_W-1:0];
			mb_s2 <= rb_abs[sesp_pkg::MAG_W-1:0];
		end
	end

	// stage 3: squares, pick the scaled axis
	logic [sesp_pkg::SQ_W-1:0] a2, b2, big_s3, small_s3;

	assign a2 = ma_s2 * ma_s2;
	assign b2 = mb_s2 * mb_s2;

	always_ff @(posedge clk) begin
		if (go[2]) begin
			big_s3   <= scale_sel_q ? b2 : a2;
			small_s3 <= scale_sel_q ? a2 : b2;
		end
	end

	// stage 4: scale times square in two halves
	logic [sesp_pkg::PP_W-1:0] pp_lo_s4, pp_hi_s4;
	logic [sesp_pkg::SQ_W-1:0] small_s4;

	always_ff @(posedge clk) begin
		if (go[3]) begin
			pp_lo_s4 <= scale_q * big_s3[sesp_pkg::HALF_W-1:0];
			pp_hi_s4 <= scale_q * big_s3[sesp_pkg::SQ_W-1:sesp_pkg::HALF_W];
			small_s4 <= small_s3;
		end
	end

	// stage 5: low half plus unscaled square
	logic [sesp_pkg::LO_W-1:0] lo_s5;
	logic [sesp_pkg::PP_W-1:0] pp_hi_s5;

	always_ff @(posedge clk) begin
		if (go[4]) begin
			lo_s5    <= sesp_pkg::LO_W'(pp_lo_s4) + sesp_pkg::LO_W'({small_s4, 8'b0});
			pp_hi_s5 <= pp_hi_s4;
		end
	end

	// stage 6: full sum, truncated distance
	logic [sesp_pkg::SUM_W-1:0] scaled;
	logic [sesp_pkg::RSQ_W-1:0] rsq_s6;

	assign scaled = sesp_pkg::SUM_W'(lo_s5)
		+ sesp_pkg::SUM_W'({pp_hi_s5, {sesp_pkg::HALF_W{1'b0}}});

	always_ff @(posedge clk) begin
		if (go[5]) begin
			rsq_s6 <= scaled[sesp_pkg::SUM_W-1:sesp_pkg::RSQ_SHIFT];
		end
	end

	// stage 7: inside test and root target rsq*n*n
	logic                    inside_s7;
	logic [sesp_pkg::T_W-1:0] t_s7;

	always_ff @(posedge clk) begin
		if (go[6]) begin
			inside_s7 <= rsq_s6 < sesp_pkg::RSQ_W'(r0sq_q);
			t_s7      <= rsq_s6[sesp_pkg::R0SQ_W-1:0] * nn_q;
		end
	end

	// root stages: largest k with k*k*r0sq <= t, one bit per stage
	logic [NR-1:0]            rk_s   [NR];
	logic [sesp_pkg::T_W-1:0] rp_s   [NR];
	logic [sesp_pkg::Q_W-1:0] rq_s   [NR];
	logic [sesp_pkg::T_W-1:0] rt_s   [NR];
	logic                     rin_s  [NR];

	for (genvar m = 0; m < NR; m++) begin : g_root
		localparam int J = NR - 1 - m;
		logic [NR-1:0]            k_i;
		logic [sesp_pkg::T_W-1:0] p_i, t_i;
		logic [sesp_pkg::Q_W-1:0] q_i;
		logic                     in_i;
		logic [sesp_pkg::T_W+1:0] trial;
		logic                     take;

		if (m == 0) begin : g_first
			assign k_i  = '0;
			assign p_i  = '0;
			assign q_i  = '0;
			assign t_i  = t_s7;
			assign in_i = inside_s7;
		end else begin : g_next
			assign k_i  = rk_s[m-1];
			assign p_i  = rp_s[m-1];
			assign q_i  = rq_s[m-1];
			assign t_i  = rt_s[m-1];
			assign in_i = rin_s[m-1];
		end

		// (k + 2^J)^2 * r0sq = p + q*2^(J+1) + r0sq*2^(2J)
		assign trial = (sesp_pkg::T_W+2)'(p_i)
			+ ((sesp_pkg::T_W+2)'(q_i) << (J + 1))
			+ ((sesp_pkg::T_W+2)'(r0sq_q) << (2 * J));
		assign take = trial <= {2'b00, t_i};

		always_ff @(posedge clk) begin
			if (go[ST_ROOT+m]) begin
				rk_s[m]  <= take ? (k_i | (NR'(1) << J)) : k_i;
				rp_s[m]  <= take ? trial[sesp_pkg::T_W-1:0] : p_i;
				rq_s[m]  <= take ? (q_i + (sesp_pkg::Q_W'(r0sq_q) << J)) : q_i;
				rt_s[m]  <= t_i;
				rin_s[m] <= in_i;
			end
		end
	end

	// output stage: shade index max(k,1)-1, saturated, zero when shading is off or the pixel is outside
	logic [NR-1:0]               kf, km1;
	logic [sesp_pkg::SHADE_W-1:0] shade;

	assign kf  = rk_s[NR-1];
	assign km1 = kf - NR'(1);

	always_comb begin
		if (!(shade_en_q && rin_s[NR-1]) || kf == '0) begin
			shade = '0;
		end else if (km1 > NR'(255)) begin
			shade = '1;
		end else begin
			shade = km1[sesp_pkg::SHADE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (go[ST_OUT]) begin
			inside_res  <= rin_s[NR-1];
			shade_index <= shade;
		end
	end

`ifndef SYNTH
	a_outside_flat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !inside_res |-> shade_index == '0)
		else $error("outside pixel with nonzero shade");

	a_shade_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !shade_en_q |-> shade_index == '0)
		else $error("shade index with shading off");

	a_zero_radius: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_ROOT] && r0sq_q == '0 |-> !rin_s[0])
		else $error("pixel inside a zero radius");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_OUT-1] && rin_s[NR-1] |-> rp_s[NR-1] <= rt_s[NR-1])
		else $error("root search overshoot");
`endif

endmodule
